FILE: src/atb_pkg.sv
// atb_pkg: shared constants, field widths and controller/datapath link types
// for the adaptive threshold binarizer. No dependencies.
package atb_pkg;

	// fixed-point scale of the decay and threshold multipliers
	localparam int FRAC_BITS = 9;
	localparam int ONE_W     = FRAC_BITS + 1;
	localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

	// default depth of the column sum store
	localparam int MAX_WIDTH_DEF = 1024;

	// field and state widths
	localparam int PIX_W = 8;
	localparam int COL_W = 10;
	localparam int LW_W  = 10;
	localparam int TP_W  = 7;
	localparam int WIN_W = LW_W - 3;
	localparam int SUM_W = 16;
	localparam int DEC_W = FRAC_BITS;
	localparam int THR_W = FRAC_BITS + 1;
	localparam int IDX_W = 2;

	// divider sizing: dividend up to 100 << FRAC_BITS, divisor up to 100 * 127
	localparam int DIV_NW = TP_W + FRAC_BITS;
	localparam int DIV_DW = 14;

	// constant factors
	localparam int INIT_MULT = 127;
	localparam int PCT_FULL  = 100;
	localparam int PCT_MAX   = 99;
	localparam logic [PIX_W-1:0] LEVEL_FG = '0;
	localparam logic [PIX_W-1:0] LEVEL_BG = 8'hff;

	// register indexes
	localparam logic [IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
	localparam logic [IDX_W-1:0] REG_THRESH_PCT = 2'd1;

	// register reset values and the settings they give
	localparam int RST_LINE_WIDTH = 320;
	localparam int RST_THRESH_PCT = 15;
	localparam int RST_WIN        = ((RST_LINE_WIDTH >> 3) < 1) ? 1 : (RST_LINE_WIDTH >> 3);
	localparam int RST_DECAY      = (1 << FRAC_BITS) - (1 << FRAC_BITS) / RST_WIN;
	localparam int RST_THRESH     = ((1 << FRAC_BITS) * (PCT_FULL - RST_THRESH_PCT))
		/ (PCT_FULL * RST_WIN);
	localparam int RST_INIT       = INIT_MULT * RST_WIN;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_in;      // take the input beat, restart frame state if marked
		logic div_start;    // launch a division
		logic div_sel_thr;  // 0: decay division, 1: threshold division
		logic div_take;     // latch the quotient
		logic mem_rd;       // read column store, decay multiply
		logic calc;         // update running sum, store, column position
		logic thr;          // threshold multiply
		logic out_load;     // fill the output register
	} atb_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic div_done;
	} atb_sts_t;

endpackage

FILE: src/atb_div.sv
// atb_div: restoring divider, one quotient bit per cycle.
// Depends on atb_pkg for nothing but is sized by its parameters.
module atb_div #(
	parameter int NW = 16,
	parameter int DW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    num_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      rem_sub;
	logic             fits;

	// one restoring step
	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign fits    = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			num_q <= {num_q[NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

FILE: src/atb_dp.sv
// atb_dp: binarizer datapath: config registers, frame settings, running sum,
// column store, multipliers and output register. Uses atb_pkg and atb_div.
module atb_dp #(
	parameter int MAX_WIDTH = atb_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  atb_pkg::atb_cmd_t         cmd,
	output atb_pkg::atb_sts_t         sts,
	input  logic                      cfg_wr,
	input  logic [atb_pkg::IDX_W-1:0] cfg_index,
	input  logic [atb_pkg::LW_W-1:0]  cfg_data,
	input  logic [atb_pkg::PIX_W-1:0] pixel,
	input  logic                      frame_start,
	output logic [atb_pkg::PIX_W-1:0] level,
	output logic [atb_pkg::COL_W-1:0] column,
	output logic                      row_end
);
	import atb_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = (AW > COL_W) ? AW : COL_W;
	localparam int FW = CW + 1;
	localparam int PRD_W = SUM_W + DEC_W;
	localparam int TPR_W = SUM_W + THR_W;
	localparam int LVL_W = TPR_W - FRAC_BITS;

	logic [LW_W-1:0]   line_width_q;
	logic [TP_W-1:0]   thresh_pct_q;
	logic [WIN_W-1:0]  win_q;
	logic [DEC_W-1:0]  decay_q;
	logic [THR_W-1:0]  thresh_q;
	logic [SUM_W-1:0]  init_q;
	logic [SUM_W-1:0]  run_sum_q;
	logic [COL_W-1:0]  col_q;
	logic              left_q;
	logic [COL_W:0]    fill_q;
	logic [PIX_W-1:0]  pix_q;
	logic [PRD_W-1:0]  prod_s1;
	logic [SUM_W-1:0]  rdata_q;
	logic [SUM_W-1:0]  avg_q;
	logic [TPR_W-1:0]  thr_s1;
	logic [COL_W-1:0]  ocol_q;
	logic              oend_q;
	logic [PIX_W-1:0]  level_q;
	logic [COL_W-1:0]  column_q;
	logic              row_end_q;
	logic [SUM_W-1:0]  mem [MAX_WIDTH];

	logic [WIN_W-1:0]  win_raw;
	logic [WIN_W-1:0]  win_next;
	logic [TP_W-1:0]   pct_sat;
	logic [TP_W-1:0]   pct_rest;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic [DIV_NW-1:0] quot;
	logic [ONE_W-1:0]  one_minus;
	logic [CW-1:0]     col_ext;
	logic [AW-1:0]     slot;
	logic              slot_written;
	logic [SUM_W-1:0]  run_sum_new;
	logic [SUM_W-1:0]  stored;
	logic [SUM_W:0]    pair_sum;
	logic [COL_W-1:0]  last_col;
	logic              end_now;
	logic [COL_W:0]    col_inc;
	logic [LVL_W-1:0]  thr_lvl;

	// window from the width as it stands, at least one
	assign win_raw  = line_width_q[LW_W-1:3];
	assign win_next = (win_raw == '0) ? WIN_W'(1) : win_raw;

	// percent saturated at the maximum
	assign pct_sat  = (thresh_pct_q > TP_W'(PCT_MAX)) ? TP_W'(PCT_MAX) : thresh_pct_q;
	assign pct_rest = TP_W'(PCT_FULL) - pct_sat;

	// division operands: one / s, or (100 - t) * one / (100 * s)
	assign div_num = cmd.div_sel_thr ? {pct_rest, {FRAC_BITS{1'b0}}} : DIV_NW'(ONE);
	assign div_den = cmd.div_sel_thr ? DIV_DW'(win_q) * DIV_DW'(PCT_FULL) : DIV_DW'(win_q);

	atb_div #(
		.NW (DIV_NW),
		.DW (DIV_DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (sts.div_done),
		.quotient (quot)
	);

	assign one_minus = ONE - quot[ONE_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LW_W'(RST_LINE_WIDTH);
			thresh_pct_q <= TP_W'(RST_THRESH_PCT);
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_LINE_WIDTH: line_width_q <= cfg_data;
				REG_THRESH_PCT: thresh_pct_q <= cfg_data[TP_W-1:0];
				default: ;
			endcase
		end
	end

	// store slot and whether it was written this frame (written slots are 0..fill-1)
	assign col_ext      = CW'(col_q);
	assign slot         = col_ext[AW-1:0];
	assign slot_written = FW'(slot) < FW'(fill_q);

	// running sum update and average with the row above
	assign run_sum_new = prod_s1[FRAC_BITS +: SUM_W] + SUM_W'(pix_q);
	assign stored      = slot_written ? rdata_q : init_q;
	assign pair_sum    = {1'b0, run_sum_new} + {1'b0, stored};

	// serpentine turn
	assign last_col = (line_width_q == '0) ? '0 : line_width_q - 1'b1;
	assign end_now  = left_q ? (col_q == '0) : (col_q >= last_col);
	assign col_inc  = {1'b0, col_q} + 1'b1;

	// frame state, running sum and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= WIN_W'(RST_WIN);
			decay_q   <= DEC_W'(RST_DECAY);
			thresh_q  <= THR_W'(RST_THRESH);
			init_q    <= SUM_W'(RST_INIT);
			run_sum_q <= SUM_W'(RST_INIT);
			col_q     <= '0;
			left_q    <= 1'b0;
			fill_q    <= '0;
		end else begin
			if (cmd.load_in && frame_start) begin
				win_q     <= win_next;
				init_q    <= SUM_W'(win_next) * SUM_W'(INIT_MULT);
				run_sum_q <= SUM_W'(win_next) * SUM_W'(INIT_MULT);
				col_q     <= '0;
				left_q    <= 1'b0;
				fill_q    <= '0;
			end
			if (cmd.div_take) begin
				if (cmd.div_sel_thr) begin
					thresh_q <= quot[THR_W-1:0];
				end else begin
					decay_q <= one_minus[DEC_W-1:0];
				end
			end
			if (cmd.calc) begin
				run_sum_q <= run_sum_new;
				if (col_inc > fill_q) begin
					fill_q <= col_inc;
				end
				if (left_q) begin
					if (end_now) begin
						left_q <= 1'b0;
					end else begin
						col_q <= col_q - 1'b1;
					end
				end else begin
					if (end_now) begin
						left_q <= 1'b1;
					end else begin
						col_q <= col_inc[COL_W-1:0];
					end
				end
			end
		end
	end

	// column sum store
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rdata_q <= mem[slot];
		end
		if (cmd.calc) begin
			mem[slot] <= run_sum_new;
		end
	end

	// item payload and arithmetic pipeline
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pix_q <= pixel;
		end
		if (cmd.mem_rd) begin
			prod_s1 <= run_sum_q * PRD_W'(decay_q);
		end
		if (cmd.calc) begin
			avg_q  <= pair_sum[SUM_W:1];
			ocol_q <= col_q;
			oend_q <= end_now;
		end
		if (cmd.thr) begin
			thr_s1 <= TPR_W'(avg_q) * TPR_W'(thresh_q);
		end
	end

	// output register
	assign thr_lvl = thr_s1[FRAC_BITS +: LVL_W];

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			level_q   <= (LVL_W'(pix_q) < thr_lvl) ? LEVEL_FG : LEVEL_BG;
			column_q  <= ocol_q;
			row_end_q <= oend_q;
		end
	end

	assign level   = level_q;
	assign column  = column_q;
	assign row_end = row_end_q;

endmodule

FILE: src/atb_ctrl.sv
// atb_ctrl: binarizer sequencer: input and output handshakes, frame setup
// divisions and the per-pixel steps. Uses atb_pkg.
module atb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              frame_start,
	output logic              out_valid,
	input  logic              out_stall,
	output atb_pkg::atb_cmd_t cmd,
	input  atb_pkg::atb_sts_t sts
);
	import atb_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_DEC_GO  = 9'b000000010,
		ST_DEC_WT  = 9'b000000100,
		ST_THR_GO  = 9'b000001000,
		ST_THR_WT  = 9'b000010000,
		ST_MEM     = 9'b000100000,
		ST_CALC    = 9'b001000000,
		ST_MUL     = 9'b010000000,
		ST_OUT     = 9'b100000000
	} atb_state_t;

	atb_state_t state_q;
	atb_state_t state_d;
	logic       out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = frame_start ? ST_DEC_GO : ST_MEM;
				end
			end
			ST_DEC_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DEC_WT;
			end
			ST_DEC_WT: begin
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = ST_THR_GO;
				end
			end
			ST_THR_GO: begin
				cmd.div_start   = 1'b1;
				cmd.div_sel_thr = 1'b1;
				state_d         = ST_THR_WT;
			end
			ST_THR_WT: begin
				cmd.div_sel_thr = 1'b1;
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = ST_MEM;
				end
			end
			ST_MEM: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.thr = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: src/adaptive_threshold_binarizer_core.sv
// Adaptive threshold binarizer: one grey pixel in, one 0/255 level out, in
// serpentine scan order, with a decaying running sum and a column store of the
// previous row's sums. The block works on one pixel at a time: a plain pixel
// passes through store read, sum update, threshold multiply and output load,
// and the next pixel is taken once its output load is done; the output load
// waits while a stalled result still sits in the output register. A pixel
// marked frame_start adds two 16-step divisions for the decay and threshold
// factors. A new pixel is taken while the previous result still waits in
// the output register. Register writes apply to the window and factors at
// the next frame start; the scan turn uses line_width at once. MAX_WIDTH
// must be a power of two.
module adaptive_threshold_binarizer_core #(
	parameter int MAX_WIDTH = atb_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [atb_pkg::PIX_W-1:0] pixel,
	input  logic                      frame_start,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [atb_pkg::PIX_W-1:0] level,
	output logic [atb_pkg::COL_W-1:0] column,
	output logic                      row_end,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [atb_pkg::IDX_W-1:0] cfg_index,
	input  logic [atb_pkg::LW_W-1:0]  cfg_data
);
	import atb_pkg::*;

	atb_cmd_t cmd;
	atb_sts_t sts;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	atb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

	atb_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel       (pixel),
		.frame_start (frame_start),
		.level       (level),
		.column      (column),
		.row_end     (row_end)
	);

	// one pixel in flight: an accepted beat stalls the input next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a pixel is in flight");

	// the datapath loads a pixel exactly on an input beat
	a_load_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in == (in_valid && !in_stall))
		else $error("pixel load does not match input beat");

	// at most one datapath step per cycle
	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.div_start, cmd.mem_rd, cmd.calc, cmd.thr,
			cmd.out_load}))
		else $error("overlapping datapath commands");

	// a loaded result is offered on the next cycle
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not offered");

endmodule
